// ===== src/uigfc_pkg.sv =====
// Shared types and constants for the UART idle-gap frame capture block.
package uigfc_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 6;
    localparam int IDLE_W = 8;

    // input item command codes
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // configuration register indexes
    localparam logic CFG_IDLE_LIMIT = 1'b0;
    localparam logic CFG_MIN_LEN    = 1'b1;

    localparam logic [IDLE_W-1:0] IDLE_LIMIT_RST = 8'd50;
    localparam logic [LEN_W-1:0]  MIN_LEN_RST    = 6'd17;

    typedef enum logic {
        ST_IDLE,
        ST_SEND
    } state_t;

    typedef struct packed {
        logic store_byte;
        logic count_tick;
        logic close_frame;
        logic rd_first;
        logic rd_step;
    } dp_cmd_t;

    typedef struct packed {
        logic close_hit;
        logic emit_ok;
        logic rd_last;
    } dp_status_t;

endpackage

// ===== src/uigfc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module uigfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/uigfc_datapath.sv =====
// Datapath: frame store, write index, idle counter, config registers, readout.
module uigfc_datapath import uigfc_pkg::*; #(
    parameter int BUFFER_DEPTH = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  dp_cmd_t           dp_cmd,
    output dp_status_t        dp_status,
    input  logic [BYTE_W-1:0] rx_byte,
    input  logic              cfg_wr,
    input  logic              cfg_index,
    input  logic [BYTE_W-1:0] cfg_data,
    output logic [BYTE_W-1:0] frame_byte,
    output logic [BYTE_W-1:0] frame_id,
    output logic [LEN_W-1:0]  frame_length,
    output logic              is_last
);

    localparam int ADDR_W = $clog2(BUFFER_DEPTH);
    localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(BUFFER_DEPTH - 1);
    localparam logic [ADDR_W-1:0] ID_POS   = ADDR_W'(2);

    logic [ADDR_W-1:0] wr_idx_reg, wr_idx_next;
    logic [IDLE_W-1:0] idle_reg, idle_next;
    logic              open_reg, open_next;
    logic [IDLE_W-1:0] idle_limit_reg, idle_limit_next;
    logic [LEN_W-1:0]  min_len_reg, min_len_next;
    logic [BYTE_W-1:0] id_reg, id_next;
    logic [BYTE_W-1:0] out_id_reg, out_id_next;
    logic [ADDR_W-1:0] len_reg, len_next;
    logic [ADDR_W-1:0] rd_idx_reg, rd_idx_next;

    logic [IDLE_W-1:0] idle_inc;
    logic [ADDR_W-1:0] rd_addr;
    logic              rd_en;

    assign idle_inc = idle_reg + IDLE_W'(1);

    // id is tracked apart from the RAM so closing can zero it without a RAM write
    always_comb
    begin
        wr_idx_next     = wr_idx_reg;
        idle_next       = idle_reg;
        open_next       = open_reg;
        id_next         = id_reg;
        idle_limit_next = idle_limit_reg;
        min_len_next    = min_len_reg;
        if (dp_cmd.store_byte)
        begin
            open_next   = 1'b1;
            idle_next   = '0;
            wr_idx_next = (wr_idx_reg == LAST_IDX) ? '0 : wr_idx_reg + ADDR_W'(1);
            if (wr_idx_reg == ID_POS)
            begin
                id_next = rx_byte;
            end
        end
        if (dp_cmd.count_tick && open_reg)
        begin
            idle_next = idle_inc;
        end
        if (dp_cmd.close_frame)
        begin
            wr_idx_next = '0;
            idle_next   = '0;
            open_next   = 1'b0;
            id_next     = '0;
        end
        if (cfg_wr)
        begin
            unique case (cfg_index)
                CFG_IDLE_LIMIT: idle_limit_next = cfg_data;
                CFG_MIN_LEN:    min_len_next    = cfg_data[LEN_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        out_id_next = out_id_reg;
        len_next    = len_reg;
        rd_idx_next = rd_idx_reg;
        if (dp_cmd.rd_first)
        begin
            out_id_next = id_reg;
            len_next    = wr_idx_reg;
            rd_idx_next = '0;
        end
        else if (dp_cmd.rd_step)
        begin
            rd_idx_next = rd_idx_reg + ADDR_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg     <= '0;
            idle_reg       <= '0;
            open_reg       <= 1'b0;
            idle_limit_reg <= IDLE_LIMIT_RST;
            min_len_reg    <= MIN_LEN_RST;
            rd_idx_reg     <= '0;
            len_reg        <= '0;
        end
        else
        begin
            wr_idx_reg     <= wr_idx_next;
            idle_reg       <= idle_next;
            open_reg       <= open_next;
            idle_limit_reg <= idle_limit_next;
            min_len_reg    <= min_len_next;
            rd_idx_reg     <= rd_idx_next;
            len_reg        <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg     <= id_next;
        out_id_reg <= out_id_next;
    end

    assign rd_en   = dp_cmd.rd_first | dp_cmd.rd_step;
    assign rd_addr = dp_cmd.rd_first ? '0 : rd_idx_reg + ADDR_W'(1);

    uigfc_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (BUFFER_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (dp_cmd.store_byte),
        .wr_addr (wr_idx_reg),
        .wr_data (rx_byte),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (frame_byte)
    );

    assign dp_status.close_hit = open_reg && (idle_inc >= idle_limit_reg);
    assign dp_status.emit_ok   = (wr_idx_reg != '0) && (LEN_W'(wr_idx_reg) >= min_len_reg);
    assign dp_status.rd_last   = (rd_idx_reg == len_reg - ADDR_W'(1));

    assign frame_id     = out_id_reg;
    assign frame_length = LEN_W'(len_reg);
    assign is_last      = dp_status.rd_last;

endmodule

// ===== src/uigfc_ctrl.sv =====
// Controller: input acceptance, frame close decision and readout sequencing.
module uigfc_ctrl import uigfc_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       cmd,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    input  dp_status_t dp_status,
    output dp_cmd_t    dp_cmd
);

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && (cmd == CMD_TICK) && dp_status.close_hit
                    && dp_status.emit_ok)
                begin
                    state_next = ST_SEND;
                end
            end
            ST_SEND:
            begin
                if (!out_stall && dp_status.rd_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall  = 1'b1;
        out_valid = 1'b0;
        dp_cmd    = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (cmd == CMD_BYTE)
                    begin
                        dp_cmd.store_byte = 1'b1;
                    end
                    else
                    begin
                        dp_cmd.count_tick  = 1'b1;
                        dp_cmd.close_frame = dp_status.close_hit;
                        dp_cmd.rd_first    = dp_status.close_hit && dp_status.emit_ok;
                    end
                end
            end
            ST_SEND:
            begin
                out_valid = 1'b1;
                // next read issued only on a taken item so RAM data holds while stalled
                dp_cmd.rd_step = !out_stall && !dp_status.rd_last;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== src/uart_idle_gap_frame_capture_core.sv =====
// A byte or a non-closing tick is taken whenever the core is idle; input never stalls then.
// A closing tick that emits a frame of N bytes: first byte valid the next cycle,
// then one byte per cycle while out_stall is low; input stalls until the last byte
// is taken.
// Throughput is set by the single read port of the frame store (one byte per cycle).
// Reset clears index, idle count and open flag; idle_limit=50, min_frame_length=17.
module uart_idle_gap_frame_capture_core import uigfc_pkg::*; #(
    parameter int BUFFER_DEPTH = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              cmd,
    input  logic [BYTE_W-1:0] rx_byte,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [BYTE_W-1:0] frame_byte,
    output logic [BYTE_W-1:0] frame_id,
    output logic [LEN_W-1:0]  frame_length,
    output logic              is_last,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [BYTE_W-1:0] cfg_data
);

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    assign cfg_ready = 1'b1;

    uigfc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .cmd       (cmd),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .dp_status (dp_status),
        .dp_cmd    (dp_cmd)
    );

    uigfc_datapath #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .dp_cmd       (dp_cmd),
        .dp_status    (dp_status),
        .rx_byte      (rx_byte),
        .cfg_wr       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .frame_byte   (frame_byte),
        .frame_id     (frame_id),
        .frame_length (frame_length),
        .is_last      (is_last)
    );

    a_no_input_during_readout: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while a frame is read out");

    a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && is_last) |=> !out_valid)
        else $error("output still valid after last byte");

    a_frame_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !is_last) |=> out_valid)
        else $error("frame readout stopped before last byte");

    a_nonzero_length: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (frame_length != '0))
        else $error("empty frame emitted");

endmodule

// ===== tb/uart_idle_gap_frame_capture_core_test.sv =====
// Self-checking testbench for the UART idle-gap frame capture core.
`timescale 1ns / 1ps

module uart_idle_gap_frame_capture_core_test;
    import uigfc_pkg::*;

    localparam int DEPTH           = 64;
    localparam int SETTLE_CYCLES   = 8;
    localparam int HOLD_CYCLES     = 300;
    localparam int WATCHDOG_LIMIT  = 2000;

    typedef struct packed {
        logic              cmd;
        logic [BYTE_W-1:0] data;
    } rx_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic [BYTE_W-1:0] id;
        logic [LEN_W-1:0]  len;
        logic              last;
    } frame_byte_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic              cmd = CMD_BYTE;
    logic [BYTE_W-1:0] rx_byte = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [BYTE_W-1:0] frame_byte;
    logic [BYTE_W-1:0] frame_id;
    logic [LEN_W-1:0]  frame_length;
    logic              is_last;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic              cfg_index = CFG_IDLE_LIMIT;
    logic [BYTE_W-1:0] cfg_data = '0;

    // shadow of the capture logic
    logic [BYTE_W-1:0] cap_store [DEPTH];
    logic [LEN_W-1:0]  cap_wr_idx = '0;
    logic [IDLE_W-1:0] cap_idle = '0;
    logic              cap_open = 1'b0;
    logic [IDLE_W-1:0] cfg_idle_lim = IDLE_LIMIT_RST;
    logic [LEN_W-1:0]  cfg_min_len = MIN_LEN_RST;

    rx_item_t    rx_items [$];
    frame_byte_t expected_bytes [$];

    int send_gap_pct = 0;
    int recv_stall_pct = 0;
    bit hold_armed = 1'b0;
    int quiet_cycles = 0;
    int errors = 0;
    int items_taken = 0;
    int bytes_checked = 0;
    int frames_seen = 0;
    int frames_dropped = 0;
    int settings_applied = 0;

    uart_idle_gap_frame_capture_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .frame_byte   (frame_byte),
        .frame_id     (frame_id),
        .frame_length (frame_length),
        .is_last      (is_last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #10 clk = ~clk;

    // Advance the shadow state by one accepted item and queue the bytes it releases.
    task automatic capture_step(input logic c, input logic [BYTE_W-1:0] b);
        frame_byte_t fb;
        int unsigned nxt;
        if (c == CMD_BYTE)
        begin
            cap_open = 1'b1;
            cap_idle = '0;
            cap_store[cap_wr_idx] = b;
            nxt = cap_wr_idx + 1;
            cap_wr_idx = (nxt >= DEPTH) ? '0 : LEN_W'(nxt);
        end
        else if (cap_open)
        begin
            cap_idle = cap_idle + 1'b1;
            if (cap_idle >= cfg_idle_lim)
            begin
                if (cap_wr_idx >= cfg_min_len)
                begin
                    for (int k = 0; k < cap_wr_idx; k++)
                    begin
                        fb.data = cap_store[k];
                        fb.id   = cap_store[2];
                        fb.len  = cap_wr_idx;
                        fb.last = (k == cap_wr_idx - 1);
                        expected_bytes.push_back(fb);
                    end
                end
                else if (cap_wr_idx != 0)
                begin
                    frames_dropped++;
                end
                cap_wr_idx = '0;
                cap_idle = '0;
                cap_store[0] = '0;
                cap_store[1] = '0;
                cap_store[2] = '0;
                cap_open = 1'b0;
            end
        end
    endtask

    function automatic void push_item(input logic c, input logic [BYTE_W-1:0] b);
        rx_items.push_back('{cmd: c, data: b});
    endfunction

    function automatic void push_ticks(input int n);
        for (int k = 0; k < n; k++)
        begin
            push_item(CMD_TICK, BYTE_W'($urandom));
        end
    endfunction

    function automatic void add_frame(input int len, input int idle_lim);
        for (int k = 0; k < len; k++)
        begin
            push_item(CMD_BYTE, BYTE_W'($urandom));
        end
        push_ticks(idle_lim);
    endfunction

    // Mostly closed frames with random content; some stray ticks and interrupted frames.
    function automatic void add_traffic(input int budget, input int idle_lim, input int min_len);
        int added;
        int len;
        int pick;
        int gap;
        added = 0;
        while (added < budget)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                if ($urandom_range(9) == 0)
                    len = $urandom_range(70, 60);
                else
                    len = $urandom_range(min_len + 6, (min_len > 2) ? min_len - 2 : 1);
                for (int k = 0; k < len; k++)
                begin
                    push_item(CMD_BYTE, BYTE_W'($urandom));
                end
                // a pause short of the limit, then the frame carries on
                if (idle_lim > 1 && $urandom_range(3) == 0)
                begin
                    gap = $urandom_range(idle_lim - 1, 1);
                    push_ticks(gap);
                    push_item(CMD_BYTE, BYTE_W'($urandom));
                    added += gap + 1;
                end
                push_ticks(idle_lim);
                added += len + idle_lim;
            end
            else if (pick < 85)
            begin
                gap = $urandom_range(3, 1);
                push_ticks(gap);
                added += gap;
            end
            else
            begin
                len = $urandom_range(4, 1);
                for (int k = 0; k < len; k++)
                begin
                    push_item(CMD_BYTE, BYTE_W'($urandom));
                end
                gap = (idle_lim > 1) ? $urandom_range(idle_lim - 1, 1) : 0;
                push_ticks(gap);
                added += len + gap;
            end
        end
    endfunction

    // rx item driver
    always @(posedge clk or negedge rst_n)
    begin : drive_rx
        rx_item_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            cmd <= CMD_BYTE;
            rx_byte <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                capture_step(cmd, rx_byte);
                items_taken++;
            end
            if (!in_valid || !in_stall)
            begin
                if (rx_items.size() != 0 && $urandom_range(99) >= send_gap_pct)
                begin
                    nxt = rx_items.pop_front();
                    in_valid <= 1'b1;
                    cmd <= nxt.cmd;
                    rx_byte <= nxt.data;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // frame byte monitor and receiver back-pressure
    always @(posedge clk or negedge rst_n)
    begin : watch_frames
        frame_byte_t want;
        int hold_left;
        bit hold_done;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $display("%0t: unexpected frame byte %0h (id %0h len %0d last %0b)",
                             $time, frame_byte, frame_id, frame_length, is_last);
                    errors++;
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (frame_byte !== want.data)
                    begin
                        $display("%0t: frame_byte expected %0h actual %0h",
                                 $time, want.data, frame_byte);
                        errors++;
                    end
                    if (frame_id !== want.id)
                    begin
                        $display("%0t: frame_id expected %0h actual %0h",
                                 $time, want.id, frame_id);
                        errors++;
                    end
                    if (frame_length !== want.len)
                    begin
                        $display("%0t: frame_length expected %0d actual %0d",
                                 $time, want.len, frame_length);
                        errors++;
                    end
                    if (is_last !== want.last)
                    begin
                        $display("%0t: is_last expected %0b actual %0b",
                                 $time, want.last, is_last);
                        errors++;
                    end
                    bytes_checked++;
                    if (want.last)
                        frames_seen++;
                end
            end
            // one long hold-off so the core backs up and stalls its input
            if (hold_left != 0)
                hold_left--;
            else if (hold_armed && !hold_done && out_valid)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : watchdog
        @(posedge rst_n);
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("%0t: no handshake for %0d cycles, %0d bytes still expected",
                 $time, quiet_cycles, expected_bytes.size());
        $display("uart_idle_gap_frame_capture_core regression: fail");
        $finish;
    end

    task automatic write_setting(input logic idx, input logic [BYTE_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_IDLE_LIMIT)
            cfg_idle_lim = val;
        else
            cfg_min_len = val[LEN_W-1:0];
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_setting(input int idle_lim, input int min_len);
        write_setting(CFG_IDLE_LIMIT, BYTE_W'(idle_lim));
        write_setting(CFG_MIN_LEN, BYTE_W'(min_len));
        settings_applied++;
        @(negedge clk);
    endtask

    // all items taken, all bytes back, then a pause for the core to settle
    task automatic wait_quiet();
        do
            @(negedge clk);
        while (rx_items.size() != 0 || in_valid || expected_bytes.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic void set_idling(input int send_pct, input int recv_pct);
        send_gap_pct = send_pct;
        recv_stall_pct = recv_pct;
    endfunction

    initial
    begin : sequence_main
        int lim;
        int mlen;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset values: 49 silent ticks do not close; 17 bytes are just long enough
        set_idling(12, 62);
        push_item(CMD_BYTE, 8'h00);
        push_item(CMD_BYTE, 8'hFF);
        add_frame(14, 49);
        push_item(CMD_BYTE, BYTE_W'($urandom));
        push_ticks(50);
        wait_quiet();

        // tick with nothing open, minimum frame, short frame
        apply_setting(1, 3);
        push_ticks(1);
        push_item(CMD_BYTE, 8'h00);
        push_item(CMD_BYTE, 8'hFF);
        push_item(CMD_BYTE, 8'hA5);
        push_ticks(1);
        push_item(CMD_BYTE, 8'h01);
        push_item(CMD_BYTE, 8'h02);
        push_ticks(1);
        wait_quiet();

        // each byte restarts the idle count
        apply_setting(3, 3);
        push_item(CMD_BYTE, 8'h5A);
        push_ticks(2);
        push_item(CMD_BYTE, 8'hC3);
        push_ticks(2);
        push_item(CMD_BYTE, 8'h3C);
        push_ticks(3);
        wait_quiet();

        // sender mostly busy, receiver mostly stalled
        apply_setting(1, 3);
        add_traffic(25, 1, 3);
        wait_quiet();

        // sender gappy, receiver mostly ready; wrapped-empty and wrapped-to-three frames
        set_idling(62, 12);
        apply_setting(2, 3);
        push_ticks(2);
        add_frame(64, 2);
        add_frame(67, 2);
        wait_quiet();
        lim = $urandom_range(12, 2);
        mlen = $urandom_range(20, 3);
        apply_setting(lim, mlen);
        add_traffic(20, lim, mlen);
        wait_quiet();

        // no idling on either side, plus one long receiver hold-off
        set_idling(0, 0);
        apply_setting(2, 3);
        hold_armed = 1'b1;
        add_frame(16, 2);
        add_frame(16, 2);
        wait_quiet();
        lim = $urandom_range(12, 1);
        mlen = $urandom_range(24, 3);
        apply_setting(lim, mlen);
        add_traffic(20, lim, mlen);
        wait_quiet();

        if (expected_bytes.size() != 0)
        begin
            $display("%0t: %0d frame bytes never arrived", $time, expected_bytes.size());
            errors++;
        end
        $display("%0d input items under %0d register settings, wrapped and held-off frames",
                 items_taken, settings_applied);
        $display("%0d frame bytes checked in %0d frames, %0d short frames dropped",
                 bytes_checked, frames_seen, frames_dropped);
        if (errors == 0)
            $display("uart_idle_gap_frame_capture_core regression: pass");
        else
            $display("uart_idle_gap_frame_capture_core regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/uigfc_pkg.sv
src/uigfc_ram.sv
src/uigfc_datapath.sv
src/uigfc_ctrl.sv
src/uart_idle_gap_frame_capture_core.sv
tb/uart_idle_gap_frame_capture_core_test.sv
